// ===== rtl/y2r_pkg.sv =====
// Shared types, widths and Q-format colour coefficients for the Y411 to RGB converter.
// Depends on nothing; the pixel pipeline, the top level and the testbench import it.
package y2r_pkg;

    localparam int COEF_FRAC_BITS = 10;

    // Coefficients stay below 4.0, so two integer bits are enough.
    localparam int COEF_W = COEF_FRAC_BITS + 2;
    // Signed coefficient times a 9-bit signed operand.
    localparam int PROD_W = COEF_W + 1 + 9;
    // Channel value after the fractional bits are dropped.
    localparam int CHAN_W = PROD_W - COEF_FRAC_BITS;

    localparam int PIXELS_PER_GROUP = 4;
    localparam int CNT_W = $clog2(PIXELS_PER_GROUP);
    localparam logic [CNT_W-1:0] LAST_PIXEL = CNT_W'(PIXELS_PER_GROUP - 1);

    localparam logic [8:0] LUMA_OFFSET = 9'd16;
    localparam logic [8:0] CHROMA_OFFSET = 9'd128;

    // Round-half-up of milli / 1000 scaled by two to the fraction bits.
    function automatic logic [COEF_W-1:0] coef_q(input int milli);
        int scaled;
        scaled = ((milli << COEF_FRAC_BITS) + 500) / 1000;
        return COEF_W'(scaled);
    endfunction

    localparam logic [COEF_W-1:0] COEF_Y = coef_q(1164);
    localparam logic [COEF_W-1:0] COEF_RV = coef_q(1596);
    localparam logic [COEF_W-1:0] COEF_GV = coef_q(813);
    localparam logic [COEF_W-1:0] COEF_GU = coef_q(391);
    localparam logic [COEF_W-1:0] COEF_BU = coef_q(2018);

    // One pixel handed from the group register to the arithmetic pipeline.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] u_chroma;
        logic [7:0] v_chroma;
        logic group_last;
        logic image_last;
    } pix_cmd_t;

    // Marks that ride along with each pixel through the pipeline.
    typedef struct packed {
        logic group_last;
        logic image_last;
    } pix_tag_t;

endpackage

// ===== rtl/y2r_grp_if.sv =====
// Valid/ready channel carrying one packed Y411 group per word.
// Depends on nothing.
interface y2r_grp_if;
    logic valid;
    logic ready;
    logic [7:0] u_chroma;
    logic [7:0] luma0;
    logic [7:0] luma1;
    logic [7:0] v_chroma;
    logic [7:0] luma2;
    logic [7:0] luma3;
    logic frame_end;

    modport source (
        output valid, u_chroma, luma0, luma1, v_chroma, luma2, luma3, frame_end,
        input ready
    );
    modport sink (
        input valid, u_chroma, luma0, luma1, v_chroma, luma2, luma3, frame_end,
        output ready
    );
endinterface

// ===== rtl/y2r_pix_if.sv =====
// Valid/ready channel carrying one RGB pixel per word, with group and image end marks.
// Depends on nothing.
interface y2r_pix_if;
    logic valid;
    logic ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic group_last;
    logic image_last;

    modport source (
        output valid, red, green, blue, group_last, image_last,
        input ready
    );
    modport sink (
        input valid, red, green, blue, group_last, image_last,
        output ready
    );
endinterface

// ===== rtl/y2r_pixel_pipe.sv =====
// Three-stage BT.601 arithmetic pipeline: products, sums, then floor and clamp.
// Depends on y2r_pkg and the y2r_pix_if output channel.
module y2r_pixel_pipe
    import y2r_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  pix_cmd_t         cmd,
    output logic             cmd_ready,
    y2r_pix_if.source        pix
);

    logic advance;

    // Stage 1: products
    logic s1_valid_reg;
    pix_tag_t s1_tag_reg;
    logic signed [PROD_W-1:0] s1_ys_reg, s1_rv_reg, s1_gv_reg, s1_gu_reg, s1_bu_reg;

    // Stage 2: channel sums
    logic s2_valid_reg;
    pix_tag_t s2_tag_reg;
    logic signed [PROD_W-1:0] s2_r_reg, s2_g_reg, s2_b_reg;

    // Stage 3: output word
    logic s3_valid_reg;
    pix_tag_t s3_tag_reg;
    logic [7:0] s3_red_reg, s3_green_reg, s3_blue_reg;

    logic signed [8:0] y_s, u_s, v_s;
    logic [7:0] red_next, green_next, blue_next;

    function automatic logic [7:0] clamp_chan(input logic signed [PROD_W-1:0] acc);
        logic [CHAN_W-1:0] whole;
        whole = acc[PROD_W-1:COEF_FRAC_BITS];
        if (whole[CHAN_W-1])
        begin
            return 8'd0;
        end
        else if (|whole[CHAN_W-2:8])
        begin
            return 8'd255;
        end
        else
        begin
            return whole[7:0];
        end
    endfunction

    // The whole pipeline moves together; it only holds when the output word is refused.
    assign advance = !s3_valid_reg || pix.ready;
    assign cmd_ready = advance;

    assign y_s = $signed({1'b0, cmd.luma} - LUMA_OFFSET);
    assign u_s = $signed({1'b0, cmd.u_chroma} - CHROMA_OFFSET);
    assign v_s = $signed({1'b0, cmd.v_chroma} - CHROMA_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= cmd_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tag_reg <= '{group_last: cmd.group_last, image_last: cmd.image_last};
            s1_ys_reg <= $signed({1'b0, COEF_Y}) * y_s;
            s1_rv_reg <= $signed({1'b0, COEF_RV}) * v_s;
            s1_gv_reg <= $signed({1'b0, COEF_GV}) * v_s;
            s1_gu_reg <= $signed({1'b0, COEF_GU}) * u_s;
            s1_bu_reg <= $signed({1'b0, COEF_BU}) * u_s;

            s2_tag_reg <= s1_tag_reg;
            s2_r_reg <= s1_ys_reg + s1_rv_reg;
            s2_g_reg <= s1_ys_reg - s1_gv_reg - s1_gu_reg;
            s2_b_reg <= s1_ys_reg + s1_bu_reg;

            s3_tag_reg <= s2_tag_reg;
            s3_red_reg <= red_next;
            s3_green_reg <= green_next;
            s3_blue_reg <= blue_next;
        end
    end

    // Dropping the fraction bits of a two's-complement value floors it.
    assign red_next = clamp_chan(s2_r_reg);
    assign green_next = clamp_chan(s2_g_reg);
    assign blue_next = clamp_chan(s2_b_reg);

    assign pix.valid = s3_valid_reg;
    assign pix.red = s3_red_reg;
    assign pix.green = s3_green_reg;
    assign pix.blue = s3_blue_reg;
    assign pix.group_last = s3_tag_reg.group_last;
    assign pix.image_last = s3_tag_reg.image_last;

endmodule

// ===== rtl/yuv411_to_rgb_converter.sv =====
// Top level of the Y411 group to RGB pixel converter (BT.601, video range).
// Depends on y2r_pkg, y2r_grp_if, y2r_pix_if and y2r_pixel_pipe.
//
// Usage:
//   grp carries one Y411 group per word (U, four luma samples, V, frame end).
//   pix carries one RGB pixel per word, luma0 first and luma3 last; the fourth
//   pixel has group_last set and repeats the group's frame_end as image_last.
//   A word moves on a rising edge of clk with valid and ready both high.
// Path: a taken group is held in the group register, and each of its pixels
//   then passes the product, sum and output-word registers on its way to pix.
// Throughput: one pixel per cycle while pix.ready stays high. The group
//   register takes the next group in the cycle its last pixel is issued.
// Reset: rst_n clears the group register and all pipeline valid bits at once;
//   the block is ready for a group in the first cycle after release.
// Stall: while pix.ready is low and a pixel waits, the whole three-stage
//   pipeline and any group in the group register hold; grp.ready stays low
//   while a group is held.
module yuv411_to_rgb_converter
    import y2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    y2r_grp_if.sink    grp,
    y2r_pix_if.source  pix
);

    logic grp_valid_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0] u_reg, v_reg, luma0_reg, luma1_reg, luma2_reg, luma3_reg;
    logic fe_reg;

    logic cmd_ready;
    logic issue, take, last_issue;
    pix_cmd_t cmd;

    assign issue = grp_valid_reg && cmd_ready;
    assign last_issue = issue && (cnt_reg == LAST_PIXEL);
    assign grp.ready = !grp_valid_reg || last_issue;
    assign take = grp.valid && grp.ready;

    always_comb
    begin
        cmd.u_chroma = u_reg;
        cmd.v_chroma = v_reg;
        cmd.group_last = (cnt_reg == LAST_PIXEL);
        cmd.image_last = (cnt_reg == LAST_PIXEL) && fe_reg;
        case (cnt_reg)
            2'd0: cmd.luma = luma0_reg;
            2'd1: cmd.luma = luma1_reg;
            2'd2: cmd.luma = luma2_reg;
            default: cmd.luma = luma3_reg;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (take)
        begin
            cnt_next = '0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (take)
            begin
                grp_valid_reg <= 1'b1;
            end
            else if (last_issue)
            begin
                grp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            u_reg <= grp.u_chroma;
            v_reg <= grp.v_chroma;
            luma0_reg <= grp.luma0;
            luma1_reg <= grp.luma1;
            luma2_reg <= grp.luma2;
            luma3_reg <= grp.luma3;
            fe_reg <= grp.frame_end;
        end
    end

    y2r_pixel_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (grp_valid_reg),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .pix       (pix)
    );

endmodule

// ===== rtl/y2r_checker.sv =====
// Port-level checks for the Y411 to RGB converter, bound to its top level.
// Depends on yuv411_to_rgb_converter and its pixel channel.
module y2r_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pix_valid,
    input logic       pix_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic       group_last,
    input logic       image_last
);

    // A refused pixel word stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=>
            pix_valid && $stable({red, green, blue, group_last, image_last}))
    else $error("pixel word changed while stalled");

    // The image can only end on the last pixel of a group.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && image_last |-> group_last)
    else $error("image end flagged away from a group end");

    // Reset leaves the pipeline empty from the next clock edge on.
    assert property (@(posedge clk) !rst_n |=> !pix_valid)
    else $error("pixel word valid during reset");

endmodule

bind yuv411_to_rgb_converter y2r_checker u_y2r_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix.valid),
    .pix_ready  (pix.ready),
    .red        (pix.red),
    .green      (pix.green),
    .blue       (pix.blue),
    .group_last (pix.group_last),
    .image_last (pix.image_last)
);

// ===== test/yuv411_to_rgb_converter_tb.sv =====
// Testbench for the Y411 to RGB converter: directed, back-pressure, random and drain-pause tests.
// Depends on y2r_pkg, y2r_grp_if, y2r_pix_if and the yuv411_to_rgb_converter RTL.
`timescale 1ns / 1ps

module yuv411_to_rgb_converter_tb;
    import y2r_pkg::*;

    localparam int FRAC = COEF_FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] u_chroma;
        logic [7:0] luma0;
        logic [7:0] luma1;
        logic [7:0] v_chroma;
        logic [7:0] luma2;
        logic [7:0] luma3;
        logic frame_end;
    } y411_group_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic group_last;
        logic image_last;
    } rgb_pixel_t;

    // Unsigned coefficient, rounded half up, with FRAC fraction bits.
    function automatic int fixed_coef(input int milli);
        return (milli * (1 << FRAC) * 2 + 1000) / 2000;
    endfunction

    localparam int K_Y = fixed_coef(1164);
    localparam int K_RV = fixed_coef(1596);
    localparam int K_GV = fixed_coef(813);
    localparam int K_GU = fixed_coef(391);
    localparam int K_BU = fixed_coef(2018);

    logic clk;
    logic rst_n;
    int mismatches;
    int cycle_count;
    int sink_hold_request;
    bit src_idle_en;
    bit snk_idle_en;
    rgb_pixel_t rgb_expected[$];

    y2r_grp_if grp ();
    y2r_pix_if pix ();

    yuv411_to_rgb_converter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .grp   (grp),
        .pix   (pix)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] clamp_channel(input int acc);
        int scaled;
        scaled = acc >>> FRAC;
        if (scaled < 0)
        begin
            return 8'd0;
        end
        if (scaled > 255)
        begin
            return 8'd255;
        end
        return scaled[7:0];
    endfunction

    function automatic rgb_pixel_t pixel_rgb(input logic [7:0] luma, input logic [7:0] u_byte,
                                             input logic [7:0] v_byte, input logic last,
                                             input logic img_end);
        int ys;
        int u;
        int v;
        rgb_pixel_t p;
        u = int'(u_byte) - 128;
        v = int'(v_byte) - 128;
        ys = K_Y * (int'(luma) - 16);
        p.red = clamp_channel(ys + K_RV * v);
        p.green = clamp_channel(ys - K_GV * v - K_GU * u);
        p.blue = clamp_channel(ys + K_BU * u);
        p.group_last = last;
        p.image_last = img_end;
        return p;
    endfunction

    // Extremes turn up more often than a flat draw would give them.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 31));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic y411_group_t rand_group();
        y411_group_t g;
        g.u_chroma = rand_byte();
        g.luma0 = rand_byte();
        g.luma1 = rand_byte();
        g.v_chroma = rand_byte();
        g.luma2 = rand_byte();
        g.luma3 = rand_byte();
        g.frame_end = ($urandom_range(0, 7) == 0);
        return g;
    endfunction

    task automatic send_group(input y411_group_t g);
        logic [7:0] lumas [4];
        int k;
        while (src_idle_en && $urandom_range(0, 99) < 34)
        begin
            grp.valid <= 1'b0;
            @(posedge clk);
        end
        grp.valid <= 1'b1;
        grp.u_chroma <= g.u_chroma;
        grp.luma0 <= g.luma0;
        grp.luma1 <= g.luma1;
        grp.v_chroma <= g.v_chroma;
        grp.luma2 <= g.luma2;
        grp.luma3 <= g.luma3;
        grp.frame_end <= g.frame_end;
        @(posedge clk);
        while (!grp.ready)
        begin
            @(posedge clk);
        end
        lumas = '{g.luma0, g.luma1, g.luma2, g.luma3};
        for (k = 0; k < 4; k++)
        begin
            rgb_expected.push_back(pixel_rgb(lumas[k], g.u_chroma, g.v_chroma, k == 3,
                                             k == 3 && g.frame_end));
        end
    endtask

    task automatic wait_drain();
        grp.valid <= 1'b0;
        while (rgb_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Sink side: random stalls, plus a long hold-off when one is requested.
    initial pix.ready = 1'b0;
    always @(posedge clk)
    begin
        static int hold_left = 0;
        if (sink_hold_request > 0)
        begin
            hold_left = sink_hold_request;
            sink_hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pix.ready <= 1'b0;
        end
        else
        begin
            pix.ready <= !snk_idle_en || ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge clk)
    begin
        rgb_pixel_t want;
        if (rst_n && pix.valid && pix.ready)
        begin
            if (rgb_expected.size() == 0)
            begin
                $error("unexpected pixel word: red %0d green %0d blue %0d", pix.red,
                       pix.green, pix.blue);
                mismatches++;
            end
            else
            begin
                want = rgb_expected.pop_front();
                check_field("red", want.red, pix.red);
                check_field("green", want.green, pix.green);
                check_field("blue", want.blue, pix.blue);
                check_field("group_last", want.group_last, pix.group_last);
                check_field("image_last", want.image_last, pix.image_last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_reset();
        clk = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        sink_hold_request = 0;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        grp.valid = 1'b0;
        grp.u_chroma = 8'd0;
        grp.luma0 = 8'd0;
        grp.luma1 = 8'd0;
        grp.v_chroma = 8'd0;
        grp.luma2 = 8'd0;
        grp.luma3 = 8'd0;
        grp.frame_end = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Field extremes, black and white, and every corner of the chroma plane.
    task automatic test_directed();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_group('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
        send_group('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
        send_group('{8'd128, 8'd16, 8'd16, 8'd128, 8'd16, 8'd16, 1'b0});
        send_group('{8'd128, 8'd235, 8'd235, 8'd128, 8'd235, 8'd235, 1'b0});
        send_group('{8'd128, 8'd0, 8'd255, 8'd128, 8'd15, 8'd17, 1'b1});
        send_group('{8'd0, 8'd0, 8'd255, 8'd0, 8'd16, 8'd235, 1'b0});
        send_group('{8'd255, 8'd128, 8'd128, 8'd255, 8'd128, 8'd128, 1'b0});
        send_group('{8'd0, 8'd16, 8'd100, 8'd255, 8'd200, 8'd255, 1'b0});
        send_group('{8'd255, 8'd255, 8'd200, 8'd0, 8'd100, 8'd16, 1'b1});
        send_group('{8'd128, 8'd60, 8'd120, 8'd0, 8'd180, 8'd240, 1'b0});
        send_group('{8'd128, 8'd60, 8'd120, 8'd255, 8'd180, 8'd240, 1'b0});
        send_group('{8'd0, 8'd30, 8'd90, 8'd128, 8'd150, 8'd210, 1'b0});
        send_group('{8'd255, 8'd30, 8'd90, 8'd128, 8'd150, 8'd210, 1'b1});
        send_group('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0});
        send_group('{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1});
        wait_drain();
    endtask

    // The sink holds off long enough for the pipeline and group register to fill.
    task automatic test_back_pressure();
        int n;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        sink_hold_request = 80;
        for (n = 0; n < 12; n++)
        begin
            send_group(rand_group());
        end
        wait_drain();
    endtask

    task automatic test_random(input int count, input bit idling);
        int n;
        src_idle_en = idling;
        snk_idle_en = idling;
        for (n = 0; n < count; n++)
        begin
            send_group(rand_group());
        end
    endtask

    // The source stops until every pixel has left, then carries on.
    task automatic test_drain_pause();
        int n;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        for (n = 0; n < 6; n++)
        begin
            send_group(rand_group());
        end
        wait_drain();
        for (n = 0; n < 6; n++)
        begin
            send_group(rand_group());
        end
        wait_drain();
    endtask

    initial
    begin
        test_reset();
        test_directed();
        test_back_pressure();
        test_random(90, 1'b0);
        test_drain_pause();
        test_random(200, 1'b1);
        wait_drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/y2r_pkg.sv
rtl/y2r_grp_if.sv
rtl/y2r_pix_if.sv
rtl/y2r_pixel_pipe.sv
rtl/yuv411_to_rgb_converter.sv
rtl/y2r_checker.sv
test/yuv411_to_rgb_converter_tb.sv
